// ----- rtl/drpf_pkg.sv -----
`default_nettype none

package drpf_pkg;

  localparam int EDGE_W    = 13;
  localparam int SPAN_W    = 25;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int OUT_BITS  = 4 + 4 * EDGE_W + KIND_W + SPAN_W + 2;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_MARK    = 2'd0;
  localparam logic [OP_W-1:0] OP_PRESENT = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET   = 2'd2;

  // flush kinds
  localparam logic [KIND_W-1:0] FLUSH_NONE = 2'd0;
  localparam logic [KIND_W-1:0] FLUSH_RECT = 2'd1;
  localparam logic [KIND_W-1:0] FLUSH_SPAN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_FLIP     = 2'd3;

  localparam logic [EDGE_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [EDGE_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [EDGE_W-1:0] RST_PITCH  = 13'd640;
  localparam logic [PROD_W-1:0] RST_FRAME_PIXELS = PROD_W'(640 * 480);

  typedef struct packed {
    logic [EDGE_W-1:0] width;
    logic [EDGE_W-1:0] height;
    logic [EDGE_W-1:0] pitch;
    logic              flip;
    logic [PROD_W-1:0] frame_pixels;
    logic              settling;
  } cfg_t;

  typedef struct packed {
    logic              presented;
    logic              seed_first;
    logic              visible_page;
    logic              draw_page;
    logic [EDGE_W-1:0] box_x1;
    logic [EDGE_W-1:0] box_y1;
    logic [EDGE_W-1:0] box_x2;
    logic [EDGE_W-1:0] box_y2;
    logic [KIND_W-1:0] flush_kind;
    logic [SPAN_W-1:0] flush_span;
    logic              copy_back;
    logic              wait_sync;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/drpf_cfg.sv -----
`default_nettype none

module drpf_cfg
  import drpf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [EDGE_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  logic [EDGE_W-1:0] width;
  logic [EDGE_W-1:0] height;
  logic [EDGE_W-1:0] pitch;
  logic              flip;
  logic [PROD_W-1:0] frame_pixels;
  logic              settling;

  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= RST_WIDTH;
      height       <= RST_HEIGHT;
      pitch        <= RST_PITCH;
      flip         <= 1'b0;
      frame_pixels <= RST_FRAME_PIXELS;
      settling     <= 1'b0;
    end else begin
      // frame pixel count is registered from the height and pitch registers, so it follows them in the next cycle
      frame_pixels <= PROD_W'(height * pitch);
      settling     <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  width  <= cfg_data;
          REG_SCREEN_HEIGHT: height <= cfg_data;
          REG_LINE_PITCH:    pitch  <= cfg_data;
          REG_PAGE_FLIP:     flip   <= cfg_data[0];
        endcase
      end
    end
  end

  assign cfg.width        = width;
  assign cfg.height       = height;
  assign cfg.pitch        = pitch;
  assign cfg.flip         = flip;
  assign cfg.frame_pixels = frame_pixels;
  assign cfg.settling     = settling;

endmodule

`default_nettype wire

// ----- rtl/drpf_engine.sv -----
`default_nettype none

module drpf_engine
  import drpf_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire cfg_t                  cfg,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic [COORD_BITS-1:0] rect_x,
  input  wire logic [COORD_BITS-1:0] rect_y,
  input  wire logic [COORD_BITS:0]   rect_w,
  input  wire logic [COORD_BITS:0]   rect_h,
  input  wire logic                  cache_on,
  input  wire logic                  sync_request,
  output result_t                    result
);

  localparam int SUM_W = ((COORD_BITS + 2) > (EDGE_W + 1)) ? (COORD_BITS + 2) : (EDGE_W + 1);

  logic              dirty, dirty_next;
  logic [EDGE_W-1:0] left, left_next;
  logic [EDGE_W-1:0] top, top_next;
  logic [EDGE_W-1:0] right, right_next;
  logic [EDGE_W-1:0] bottom, bottom_next;
  logic              front, front_next;
  logic              back, back_next;
  logic              seeded, seeded_next;

  logic [SUM_W-1:0]  x_ext, y_ext, sw_ext, sh_ext, sum_x, sum_y;
  logic [EDGE_W-1:0] clip_x1, clip_y1, clip_x2, clip_y2;
  logic              rect_ok;

  logic [EDGE_W-1:0] bw, bh, bh_less;
  logic [PROD_W-1:0] area, span_prod;
  logic [PROD_W:0]   span_sum;
  logic [PROD_W+1:0] area_x4;

  logic              seed, presented, copy_back, wait_sync;
  logic [KIND_W-1:0] kind;
  logic [SPAN_W-1:0] span;
  logic [EDGE_W-1:0] bx1, by1, bx2, by2;

  // clip the rectangle against the screen
  assign x_ext   = SUM_W'(rect_x);
  assign y_ext   = SUM_W'(rect_y);
  assign sw_ext  = SUM_W'(cfg.width);
  assign sh_ext  = SUM_W'(cfg.height);
  assign sum_x   = x_ext + SUM_W'(rect_w);
  assign sum_y   = y_ext + SUM_W'(rect_h);
  assign clip_x1 = EDGE_W'(x_ext);
  assign clip_y1 = EDGE_W'(y_ext);
  assign clip_x2 = (sum_x > sw_ext) ? cfg.width : EDGE_W'(sum_x);
  assign clip_y2 = (sum_y > sh_ext) ? cfg.height : EDGE_W'(sum_y);
  assign rect_ok = (rect_w != '0) && (rect_h != '0) && (x_ext < sw_ext) && (y_ext < sh_ext);

  // box geometry for a present, taken from the stored box
  assign bw        = (right > left) ? right - left : '0;
  assign bh        = (bottom > top) ? bottom - top : '0;
  assign bh_less   = (bh != '0) ? bh - 1'b1 : '0;
  assign span_prod = bh_less * cfg.pitch;
  assign span_sum  = (PROD_W + 1)'(span_prod) + (PROD_W + 1)'(bw);
  assign area      = bw * bh;
  assign area_x4   = {area, 2'b00};

  always_comb begin
    dirty_next  = dirty;
    left_next   = left;
    top_next    = top;
    right_next  = right;
    bottom_next = bottom;
    front_next  = front;
    back_next   = back;
    seeded_next = seeded;
    seed        = 1'b0;
    presented   = 1'b0;
    copy_back   = 1'b0;
    wait_sync   = 1'b0;
    kind        = FLUSH_NONE;
    span        = '0;

    unique case (operation)
      OP_MARK: begin
        if (cfg.flip && !seeded) begin
          seed        = 1'b1;
          seeded_next = 1'b1;
        end
        if (rect_ok) begin
          dirty_next = 1'b1;
          if (!dirty) begin
            left_next   = clip_x1;
            top_next    = clip_y1;
            right_next  = clip_x2;
            bottom_next = clip_y2;
          end else begin
            if (clip_x1 < left)   left_next   = clip_x1;
            if (clip_y1 < top)    top_next    = clip_y1;
            if (clip_x2 > right)  right_next  = clip_x2;
            if (clip_y2 > bottom) bottom_next = clip_y2;
          end
        end
      end
      OP_RESET: begin
        front_next  = 1'b0;
        back_next   = cfg.flip;
        seeded_next = 1'b1;
        dirty_next  = 1'b0;
        left_next   = '0;
        top_next    = '0;
        right_next  = '0;
        bottom_next = '0;
      end
      default: ;
    endcase

    bx1 = left_next;
    by1 = top_next;
    bx2 = right_next;
    by2 = bottom_next;

    if (operation == OP_PRESENT && dirty) begin
      presented = 1'b1;
      if (!cfg.flip) begin
        if (cache_on) kind = FLUSH_RECT;
      end else begin
        if (cache_on) begin
          kind = FLUSH_SPAN;
          span = span_sum[SPAN_W-1:0];
        end
        wait_sync  = sync_request;
        front_next = back;
        back_next  = ~back;
        // small boxes are copied back, large ones leave the draw page stale
        if (area_x4 < (PROD_W + 2)'(cfg.frame_pixels)) begin
          copy_back   = 1'b1;
          seeded_next = 1'b1;
        end else begin
          seeded_next = 1'b0;
        end
      end
      dirty_next  = 1'b0;
      left_next   = '0;
      top_next    = '0;
      right_next  = '0;
      bottom_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty  <= 1'b0;
      left   <= '0;
      top    <= '0;
      right  <= '0;
      bottom <= '0;
      front  <= 1'b0;
      back   <= 1'b0;
      seeded <= 1'b1;
    end else if (fire) begin
      dirty  <= dirty_next;
      left   <= left_next;
      top    <= top_next;
      right  <= right_next;
      bottom <= bottom_next;
      front  <= front_next;
      back   <= back_next;
      seeded <= seeded_next;
    end
  end

  assign result.presented    = presented;
  assign result.seed_first   = seed;
  assign result.visible_page = cfg.flip & front_next;
  assign result.draw_page    = cfg.flip & back_next;
  assign result.box_x1       = bx1;
  assign result.box_y1       = by1;
  assign result.box_x2       = bx2;
  assign result.box_y2       = by2;
  assign result.flush_kind   = kind;
  assign result.flush_span   = span;
  assign result.copy_back    = copy_back;
  assign result.wait_sync    = wait_sync;

`ifndef ASSERT_OFF
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    dirty |-> (right > left) && (bottom > top))
    else $error("dirty box has empty extent");

  a_present_clears: assert property (@(posedge clk) disable iff (rst)
    fire && operation == OP_PRESENT && dirty |=> !dirty)
    else $error("box still dirty after present");

  a_reset_op: assert property (@(posedge clk) disable iff (rst)
    fire && operation == OP_RESET |=> !dirty && seeded && !front)
    else $error("reset operation left page state behind");

  a_seed_only_mark: assert property (@(posedge clk) disable iff (rst)
    fire && seed |=> seeded)
    else $error("seed reported but draw page not seeded");
`endif

endmodule

`default_nettype wire

// ----- rtl/dirty_rect_page_flip_presenter.sv -----
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata rect and present flags
// m_       | out | m_tvalid/m_tready  | m_tdata presentation result
// cfg_     | in  | cfg_write          | cfg_index register, cfg_data value
//
// one item per cycle sustained while results are taken and no configuration write intervenes;
// an accepted item waits in the input register and moves to the output register when it fires
// the box, page and seeding state update as the item moves into the output register
// the cycle after a configuration write no item moves on, while the frame size settles
// rst is synchronous, active high; clears the handshake valids, the engine state and the configuration registers
// a stalled output holds its result; the input register still takes one more item
`default_nettype none

module dirty_rect_page_flip_presenter
  import drpf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  localparam int IN_BITS = 4 * COORD_BITS + 4,
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // rect_x, rect_y, rect_w, rect_h, cache_on, sync_request
  input  wire logic [IN_W-1:0]      s_tdata,
  // operation
  input  wire logic [OP_W-1:0]      s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // presented, seed_first, visible_page, draw_page, box_x1, box_y1, box_x2, box_y2,
  // flush_kind, flush_span, copy_back, wait_sync
  output logic [OUT_W-1:0]          m_tdata,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [EDGE_W-1:0]    cfg_data
);

  localparam int CB = COORD_BITS;

  cfg_t    cfg;
  result_t res;

  logic                 in_valid;
  logic [OP_W-1:0]      in_op;
  logic [IN_BITS-1:0]   in_data;
  logic                 fire;
  logic                 take;
  logic                 out_valid;
  logic [OUT_BITS-1:0]  out_data;

  assign fire     = in_valid && !cfg.settling && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op   <= s_tuser;
      in_data <= s_tdata[IN_BITS-1:0];
    end
  end

  drpf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  drpf_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .cfg          (cfg),
    .operation    (in_op),
    .rect_x       (in_data[CB-1:0]),
    .rect_y       (in_data[2*CB-1:CB]),
    .rect_w       (in_data[3*CB:2*CB]),
    .rect_h       (in_data[4*CB+1:3*CB+1]),
    .cache_on     (in_data[4*CB+2]),
    .sync_request (in_data[4*CB+3]),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {res.wait_sync, res.copy_back, res.flush_span, res.flush_kind,
                   res.box_y2, res.box_x2, res.box_y1, res.box_x1,
                   res.draw_page, res.visible_page, res.seed_first, res.presented};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import drpf_pkg::*;

  localparam int COORD_W = 12;
  localparam int IN_W = ((4 * COORD_W + 4 + 7) / 8) * 8;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    bit presented;
    bit seed_first;
    bit visible_page;
    bit draw_page;
    bit [EDGE_W-1:0] box_x1;
    bit [EDGE_W-1:0] box_y1;
    bit [EDGE_W-1:0] box_x2;
    bit [EDGE_W-1:0] box_y2;
    bit [KIND_W-1:0] flush_kind;
    bit [SPAN_W-1:0] flush_span;
    bit copy_back;
    bit wait_sync;
  } frame_result_t;

  // dirty box and page state, updated as items are accepted
  class presentation_tracker;
    bit [EDGE_W-1:0] width = RST_WIDTH;
    bit [EDGE_W-1:0] height = RST_HEIGHT;
    bit [EDGE_W-1:0] pitch = RST_PITCH;
    bit flip;
    bit dirty;
    bit [EDGE_W-1:0] left, top, right, bottom;
    bit front, back;
    bit seeded = 1'b1;
    frame_result_t pending_results[$];
    int mismatches, results_seen, presents_seen, flips_seen, copies_seen, seeds_seen;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [EDGE_W-1:0] value);
      case (idx)
        REG_SCREEN_WIDTH:  width = value;
        REG_SCREEN_HEIGHT: height = value;
        REG_LINE_PITCH:    pitch = value;
        REG_PAGE_FLIP:     flip = value[0];
        default: ;
      endcase
    endfunction

    function void clear_box();
      dirty = 1'b0;
      left = '0;
      top = '0;
      right = '0;
      bottom = '0;
    endfunction

    function void take_item(logic [OP_W-1:0] op, logic [IN_W-1:0] data);
      frame_result_t r;
      int unsigned x, y, w, h, x2, y2, bw, bh;
      bit cache, sync;
      r = '{default: 0};
      x = data[11:0];
      y = data[23:12];
      w = data[36:24];
      h = data[49:37];
      cache = data[50];
      sync = data[51];
      if (op == OP_MARK) begin
        // seeding is reported even if the rectangle is dropped
        if (flip && !seeded) begin
          r.seed_first = 1'b1;
          seeded = 1'b1;
          seeds_seen++;
        end
        if (w != 0 && h != 0 && x < width && y < height) begin
          x2 = x + w;
          y2 = y + h;
          if (x2 > width) x2 = width;
          if (y2 > height) y2 = height;
          if (!dirty) begin
            left = x;
            top = y;
            right = x2;
            bottom = y2;
            dirty = 1'b1;
          end else begin
            if (x < left) left = x;
            if (y < top) top = y;
            if (x2 > right) right = x2;
            if (y2 > bottom) bottom = y2;
          end
        end
      end else if (op == OP_RESET) begin
        front = 1'b0;
        back = flip;
        seeded = 1'b1;
        clear_box();
      end
      // reported box is the one before a present clears it
      r.box_x1 = left;
      r.box_y1 = top;
      r.box_x2 = right;
      r.box_y2 = bottom;
      if (op == OP_PRESENT && dirty) begin
        bw = right > left ? right - left : 0;
        bh = bottom > top ? bottom - top : 0;
        r.presented = 1'b1;
        presents_seen++;
        if (!flip) begin
          if (cache) r.flush_kind = FLUSH_RECT;
        end else begin
          if (cache) begin
            r.flush_kind = FLUSH_SPAN;
            r.flush_span = SPAN_W'((bh > 0 ? bh - 1 : 0) * pitch + bw);
          end
          r.wait_sync = sync;
          front = back;
          back = ~back;
          flips_seen++;
          // small boxes are copied back, large ones leave the draw page stale
          if (64'(bw) * 64'(bh) * 64'd4 < 64'(height) * 64'(pitch)) begin
            r.copy_back = 1'b1;
            seeded = 1'b1;
            copies_seen++;
          end else begin
            seeded = 1'b0;
          end
        end
        clear_box();
      end
      r.visible_page = flip ? front : 1'b0;
      r.draw_page = flip ? back : 1'b0;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [SPAN_W-1:0] want, logic [SPAN_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      frame_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no item pending: %h", data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare("presented", want.presented, data[0]);
      compare("seed_first", want.seed_first, data[1]);
      compare("visible_page", want.visible_page, data[2]);
      compare("draw_page", want.draw_page, data[3]);
      compare("box_x1", want.box_x1, data[16:4]);
      compare("box_y1", want.box_y1, data[29:17]);
      compare("box_x2", want.box_x2, data[42:30]);
      compare("box_y2", want.box_y2, data[55:43]);
      compare("flush_kind", want.flush_kind, data[57:56]);
      compare("flush_span", want.flush_span, data[82:58]);
      compare("copy_back", want.copy_back, data[83]);
      compare("wait_sync", want.wait_sync, data[84]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = OP_MARK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [EDGE_W-1:0] cfg_data = '0;

  bit calm;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int cycles;
  int items_sent;
  int settings_used;
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;
  presentation_tracker tracker;

  dirty_rect_page_flip_presenter uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               tracker.pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, int unsigned x, int unsigned y,
                           int unsigned w, int unsigned h, bit cache, bit sync);
    // idle cycles come one at a time with equal odds each cycle
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= IN_W'({sync, cache, h[12:0], w[12:0], y[11:0], x[11:0]});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EDGE_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  // registers change only once every result is out and the pipeline has drained
  task automatic configure(int unsigned wd, int unsigned ht, int unsigned pt, bit fl);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_SCREEN_WIDTH, wd);
    write_reg(REG_SCREEN_HEIGHT, ht);
    write_reg(REG_LINE_PITCH, pt);
    write_reg(REG_PAGE_FLIP, fl);
    cfg_write <= 1'b0;
    cur_w = wd;
    cur_h = ht;
    settings_used++;
  endtask

  function automatic void random_rect(output int unsigned x, output int unsigned y,
                                      output int unsigned w, output int unsigned h);
    int unsigned kind, span_x, span_y;
    kind = $urandom_range(99);
    span_x = cur_w == 0 ? 1 : cur_w;
    span_y = cur_h == 0 ? 1 : cur_h;
    if (kind < 55) begin
      x = $urandom_range(span_x - 1);
      y = $urandom_range(span_y - 1);
      w = $urandom_range(span_x / 4 + 1, 1);
      h = $urandom_range(span_y / 4 + 1, 1);
    end else if (kind < 75) begin
      // large, usually clipped at the right or bottom edge
      x = $urandom_range(span_x / 2);
      y = $urandom_range(span_y / 2);
      w = $urandom_range(4096, span_x / 2);
      h = $urandom_range(4096, span_y / 2);
    end else if (kind < 83) begin
      x = $urandom_range(span_x - 1);
      y = $urandom_range(span_y - 1);
      w = $urandom_range(1) ? 0 : $urandom_range(4096);
      h = w == 0 ? $urandom_range(4096) : 0;
    end else if (kind < 91) begin
      // corner on or past the screen edge where the screen is under 4096 wide or high
      x = cur_w <= 4095 ? $urandom_range(4095, cur_w) : $urandom_range(4095);
      y = cur_h <= 4095 ? $urandom_range(4095, cur_h) : $urandom_range(4095);
      w = $urandom_range(4096, 1);
      h = $urandom_range(4096, 1);
    end else begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
      w = $urandom_range(3) == 0 ? 4096 : $urandom_range(4096);
      h = $urandom_range(3) == 0 ? 4096 : $urandom_range(4096);
    end
  endfunction

  task automatic random_phase(int count);
    repeat (count) begin
      int unsigned pick, x, y, w, h;
      logic [OP_W-1:0] op;
      pick = $urandom_range(99);
      if (pick < 62) op = OP_MARK;
      else if (pick < 88) op = OP_PRESENT;
      else if (pick < 94) op = OP_RESET;
      else op = OP_SPARE;
      random_rect(x, y, w, h);
      send_item(op, x, y, w, h, $urandom_range(1), $urandom_range(1));
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // single page, reset settings
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 1);
    send_item(OP_MARK, 0, 0, 0, 5, 0, 0);
    send_item(OP_MARK, 0, 0, 5, 0, 0, 0);
    send_item(OP_MARK, 640, 10, 5, 5, 0, 0);
    send_item(OP_MARK, 10, 480, 5, 5, 0, 0);
    send_item(OP_MARK, 4095, 4095, 4096, 4096, 1, 1);
    send_item(OP_MARK, 600, 400, 4096, 4096, 0, 0);
    send_item(OP_MARK, 10, 20, 30, 40, 0, 0);
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 1);
    send_item(OP_SPARE, 4095, 4095, 4096, 4096, 1, 1);
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 0);

    // flipping on
    configure(640, 480, 640, 1);
    send_item(OP_MARK, 0, 0, 1, 1, 0, 0);
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 1);
    send_item(OP_MARK, 0, 0, 640, 480, 0, 0);
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 0);
    send_item(OP_MARK, 0, 0, 0, 0, 0, 0);
    send_item(OP_MARK, 5, 5, 10, 10, 0, 0);
    send_item(OP_RESET, 0, 0, 0, 0, 0, 0);
    send_item(OP_MARK, 100, 50, 20, 10, 0, 0);
    send_item(OP_PRESENT, 0, 0, 0, 0, 0, 1);
    send_item(OP_SPARE, 0, 0, 0, 0, 0, 0);

    // largest screen in this test: the span reaches 4096 * 4096
    configure(4096, 4096, 4096, 1);
    send_item(OP_MARK, 0, 0, 4096, 4096, 0, 0);
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 1);
    send_item(OP_MARK, 4095, 4095, 1, 1, 0, 0);
    send_item(OP_PRESENT, 0, 0, 0, 0, 1, 0);

    configure(640, 480, 640, 0);
    calm <= 1'b1;
    random_phase(PHASE_ITEMS);
    calm <= 1'b0;

    configure(640, 480, 640, 1);
    random_phase(PHASE_ITEMS);

    configure(4096, 4096, 4096, 1);
    random_phase(PHASE_ITEMS);
    send_item(OP_MARK, 2000, 2000, 100, 100, 0, 0);

    // shrinking the screen leaves the old box in place
    configure(1, 1, 1, 1);
    random_phase(PHASE_ITEMS / 2);

    configure(0, 0, 640, 1);
    random_phase(PHASE_ITEMS / 2);

    configure(100, 60, 128, 1);
    hold_req <= 1'b1;
    random_phase(PHASE_ITEMS);

    configure($urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(4096, 1),
              $urandom_range(1));
    random_phase(PHASE_ITEMS);

    configure(320, 200, 4096, 0);
    random_phase(PHASE_ITEMS);

    configure($urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(96, 1), 1);
    random_phase(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items over %0d register settings, %0d results checked",
             items_sent, settings_used + 1, tracker.results_seen);
    $display("%0d presents, %0d page flips, %0d copy-backs, %0d page seeds",
             tracker.presents_seen, tracker.flips_seen, tracker.copies_seen,
             tracker.seeds_seen);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
